@@ hw/rtl/svf_pkg.sv @@
// Shared constants and types for the state variable filter.
`default_nettype none

package svf_pkg;

   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int SEL_W       = 2;

   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [SEL_W-1:0]       sel_type;

   localparam csr_index_type CSR_CUTOFF_GAIN   = 3'd0;
   localparam csr_index_type CSR_DAMPING       = 3'd1;
   localparam csr_index_type CSR_NORMALIZER    = 3'd2;
   localparam csr_index_type CSR_OUTPUT_SELECT = 3'd3;

   localparam sel_type SEL_LOWPASS  = 2'd0;
   localparam sel_type SEL_BANDPASS = 2'd1;
   localparam sel_type SEL_HIGHPASS = 2'd2;

   localparam csr_data_type CUTOFF_GAIN_RESET = 24'd1048576;
   localparam csr_data_type DAMPING_RESET     = 24'd65536;
   localparam csr_data_type NORMALIZER_RESET  = 24'd8388608;
   localparam sel_type      SELECT_RESET      = SEL_LOWPASS;

   // coefficient multiplier operand: damping*16 + gain needs 29 bits
   localparam int COEF_W     = 29;
   localparam int DAMP_SHIFT = 4;
   localparam int GAIN_FRAC  = 20;
   localparam int NORM_FRAC  = 23;

endpackage

`default_nettype wire

@@ hw/rtl/svf_req_if.sv @@
// Sample input channel of the state variable filter.
`default_nettype none

interface svf_req_if #(
   parameter int SAMPLE_WIDTH = 16
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/svf_rsp_if.sv @@
// Result channel of the state variable filter.
`default_nettype none

interface svf_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] lowpass_out;
   logic signed [SAMPLE_WIDTH-1:0] bandpass_out;
   logic signed [SAMPLE_WIDTH-1:0] highpass_out;
   logic signed [SAMPLE_WIDTH-1:0] selected_out;

   modport source (output valid, output lowpass_out, output bandpass_out,
                   output highpass_out, output selected_out, input ready);
   modport sink   (input valid, input lowpass_out, input bandpass_out,
                   input highpass_out, input selected_out, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/state_variable_filter_core.sv @@
// Trapezoidal state variable filter core with one shared coefficient multiplier.
// A new sample is accepted only in idle, so each sample runs through the whole sequence
// before the next is taken. Four multiplies (lo half, hi half, round/saturate steps)
// plus six saturating add steps run on one sequencer.
// A full output register stalls the last step until the result beat is taken.
// Synchronous reset clears both integrators and loads the coefficient defaults.
`default_nettype none

module state_variable_filter_core #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int STATE_WIDTH  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   svf_req_if.sink               req_chan,
   svf_rsp_if.source             rsp_chan,
   input  logic                  csr_write_enable,
   input  svf_pkg::csr_index_type csr_index,
   input  svf_pkg::csr_data_type  csr_write_data
);
   import svf_pkg::*;

   localparam int FRAC   = STATE_WIDTH - 9;
   localparam int SCALE  = FRAC - (SAMPLE_WIDTH - 1);
   localparam int UP     = (SCALE > 0) ? SCALE : 0;
   localparam int DN     = (SCALE < 0) ? -SCALE : 0;
   localparam int HALF_W = (STATE_WIDTH + 1) / 2;
   localparam int HIGH_W = STATE_WIDTH - HALF_W;
   localparam int PLO_W  = HALF_W + COEF_W;
   localparam int PHI_W  = HIGH_W + COEF_W;
   localparam int ACC_W  = STATE_WIDTH + COEF_W + 1;
   localparam int IN_MAG_W  = SAMPLE_WIDTH + UP + 1;
   localparam int OUT_MAG_W = STATE_WIDTH + DN + 1;

   typedef logic signed [STATE_WIDTH-1:0]  state_type;
   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   localparam state_type STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
   localparam state_type STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   localparam logic [IN_MAG_W-1:0]  IN_RND  = IN_MAG_W'((64'd1 << DN) >> 1);
   localparam logic [OUT_MAG_W-1:0] OUT_RND = OUT_MAG_W'((64'd1 << UP) >> 1);
   localparam logic [OUT_MAG_W-1:0] OUT_MAX = OUT_MAG_W'((64'd1 << (SAMPLE_WIDTH-1)) - 64'd1);
   localparam logic [OUT_MAG_W-1:0] OUT_LIM = OUT_MAG_W'(64'd1 << (SAMPLE_WIDTH-1));
   localparam logic [ACC_W-1:0] PROD_LIM = ACC_W'(64'd1 << (STATE_WIDTH-1));
   localparam logic [ACC_W-1:0] RND_GAIN = ACC_W'(64'd1 << (GAIN_FRAC-1));
   localparam logic [ACC_W-1:0] RND_NORM = ACC_W'(64'd1 << (NORM_FRAC-1));

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_K_LO   = 5'd1;
   localparam logic [4:0] S_K_HI   = 5'd2;
   localparam logic [4:0] S_K_FIN  = 5'd3;
   localparam logic [4:0] S_T_X    = 5'd4;
   localparam logic [4:0] S_T_S    = 5'd5;
   localparam logic [4:0] S_N_LO   = 5'd6;
   localparam logic [4:0] S_N_HI   = 5'd7;
   localparam logic [4:0] S_N_FIN  = 5'd8;
   localparam logic [4:0] S_G1_LO  = 5'd9;
   localparam logic [4:0] S_G1_HI  = 5'd10;
   localparam logic [4:0] S_G1_FIN = 5'd11;
   localparam logic [4:0] S_BP     = 5'd12;
   localparam logic [4:0] S_G2_LO  = 5'd13;
   localparam logic [4:0] S_G2_HI  = 5'd14;
   localparam logic [4:0] S_G2_FIN = 5'd15;
   localparam logic [4:0] S_LP     = 5'd16;
   localparam logic [4:0] S_FI     = 5'd17;
   localparam logic [4:0] S_SI     = 5'd18;

   function automatic state_type sat_add(state_type a, state_type b, logic sub);
      logic signed [STATE_WIDTH:0] s;
      s = sub ? ({a[STATE_WIDTH-1], a} - {b[STATE_WIDTH-1], b})
              : ({a[STATE_WIDTH-1], a} + {b[STATE_WIDTH-1], b});
      if (s[STATE_WIDTH] != s[STATE_WIDTH-1]) begin
         return s[STATE_WIDTH] ? STATE_MIN : STATE_MAX;
      end
      return s[STATE_WIDTH-1:0];
   endfunction

   function automatic state_type to_state(sample_type s);
      logic                          neg;
      logic [SAMPLE_WIDTH:0]         ext;
      logic [SAMPLE_WIDTH:0]         abs_v;
      logic [IN_MAG_W-1:0]           m;
      logic signed [IN_MAG_W:0]      sv;
      neg   = s[SAMPLE_WIDTH-1];
      ext   = {s[SAMPLE_WIDTH-1], s};
      abs_v = neg ? (~ext + 1'b1) : ext;
      m     = IN_MAG_W'(abs_v);
      m     = ((m + IN_RND) >> DN) << UP;
      sv    = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
      return STATE_WIDTH'(sv);
   endfunction

   function automatic sample_type to_out(state_type v);
      logic                   neg;
      logic [STATE_WIDTH:0]   ext;
      logic [STATE_WIDTH:0]   abs_v;
      logic [OUT_MAG_W-1:0]   m;
      neg   = v[STATE_WIDTH-1];
      ext   = {v[STATE_WIDTH-1], v};
      abs_v = neg ? (~ext + 1'b1) : ext;
      m     = OUT_MAG_W'(abs_v);
      m     = ((m + OUT_RND) >> UP) << DN;
      if (!neg && (m > OUT_MAX)) begin
         return SAMPLE_MAX;
      end
      if (neg && (m > OUT_LIM)) begin
         return SAMPLE_MIN;
      end
      return neg ? SAMPLE_WIDTH'(~m + 1'b1) : SAMPLE_WIDTH'(m);
   endfunction

   // configuration
   csr_data_type gain_ff, gain_in;
   csr_data_type damping_ff, damping_in;
   csr_data_type norm_ff, norm_in;
   sel_type      select_ff, select_in;

   // sequencer and datapath
   logic [4:0]  state_ff, state_in;
   state_type   x_ff, x_in;
   state_type   t_ff, t_in;
   state_type   hp_ff, hp_in;
   state_type   ghp_ff, ghp_in;
   state_type   bp_ff, bp_in;
   state_type   gbp_ff, gbp_in;
   state_type   lp_ff, lp_in;
   state_type   fi_ff, fi_in;
   state_type   si_ff, si_in;
   state_type   prod_ff, prod_in;
   logic [PLO_W-1:0]  plo_ff, plo_in;
   logic [PHI_W-1:0]  phi_ff, phi_in;
   logic [HIGH_W-1:0] mag_hi_ff, mag_hi_in;
   logic [COEF_W-1:0] coef_ff, coef_in;
   logic              neg_ff, neg_in;
   logic              norm_shift_ff, norm_shift_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   sample_type  lp_out_ff, lp_out_in;
   sample_type  bp_out_ff, bp_out_in;
   sample_type  hp_out_ff, hp_out_in;
   sample_type  sel_out_ff, sel_out_in;

   logic              req_acc;
   logic              is_lo;
   logic              is_hi;
   logic              is_fin;
   logic              advance;
   state_type         op_a;
   logic [COEF_W-1:0] c_sel;
   logic [COEF_W-1:0] k_coef;
   logic [STATE_WIDTH:0] op_ext;
   logic [STATE_WIDTH:0] op_abs;
   logic [HALF_W-1:0] mul_x;
   logic [COEF_W-1:0] mul_c;
   logic [PLO_W-1:0]  mul_p;
   logic [ACC_W-1:0]  acc_sum;
   logic [ACC_W-1:0]  acc_shr;
   state_type         fin_val;
   state_type         add_a;
   state_type         add_b;
   logic              add_sub;
   state_type         add_y;
   sample_type        lp_conv;
   sample_type        bp_conv;
   sample_type        hp_conv;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign advance        = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.lowpass_out  = lp_out_ff;
   assign rsp_chan.bandpass_out = bp_out_ff;
   assign rsp_chan.highpass_out = hp_out_ff;
   assign rsp_chan.selected_out = sel_out_ff;

   assign is_lo  = (state_ff == S_K_LO) || (state_ff == S_N_LO) ||
                   (state_ff == S_G1_LO) || (state_ff == S_G2_LO);
   assign is_hi  = (state_ff == S_K_HI) || (state_ff == S_N_HI) ||
                   (state_ff == S_G1_HI) || (state_ff == S_G2_HI);
   assign is_fin = (state_ff == S_K_FIN) || (state_ff == S_N_FIN) ||
                   (state_ff == S_G1_FIN) || (state_ff == S_G2_FIN);

   assign k_coef = (COEF_W'(damping_ff) << DAMP_SHIFT) + COEF_W'(gain_ff);

   // multiplier operand select
   always_comb begin
      op_a  = fi_ff;
      c_sel = k_coef;
      case (state_ff)
         S_N_LO: begin
            op_a  = t_ff;
            c_sel = COEF_W'(norm_ff);
         end
         S_G1_LO: begin
            op_a  = prod_ff;
            c_sel = COEF_W'(gain_ff);
         end
         S_G2_LO: begin
            op_a  = bp_ff;
            c_sel = COEF_W'(gain_ff);
         end
         default: begin
            op_a  = fi_ff;
            c_sel = k_coef;
         end
      endcase
   end

   assign op_ext = {op_a[STATE_WIDTH-1], op_a};
   assign op_abs = op_a[STATE_WIDTH-1] ? (~op_ext + 1'b1) : op_ext;
   assign mul_x  = is_lo ? op_abs[HALF_W-1:0] : HALF_W'(mag_hi_ff);
   assign mul_c  = is_lo ? c_sel : coef_ff;
   assign mul_p  = mul_x * mul_c;

   // exact product, round half away from zero on the magnitude, saturate
   assign acc_sum = ACC_W'(plo_ff) + (ACC_W'(phi_ff) << HALF_W) +
                    (norm_shift_ff ? RND_NORM : RND_GAIN);
   assign acc_shr = norm_shift_ff ? (acc_sum >> NORM_FRAC) : (acc_sum >> GAIN_FRAC);

   always_comb begin
      if (acc_shr >= PROD_LIM) begin
         fin_val = neg_ff ? STATE_MIN : STATE_MAX;
      end else begin
         fin_val = neg_ff ? STATE_WIDTH'(~acc_shr + 1'b1) : STATE_WIDTH'(acc_shr);
      end
   end

   // shared saturating adder
   always_comb begin
      add_a   = gbp_ff;
      add_b   = lp_ff;
      add_sub = 1'b0;
      case (state_ff)
         S_T_X: begin
            add_a   = x_ff;
            add_b   = prod_ff;
            add_sub = 1'b1;
         end
         S_T_S: begin
            add_a   = t_ff;
            add_b   = si_ff;
            add_sub = 1'b1;
         end
         S_BP: begin
            add_a = prod_ff;
            add_b = fi_ff;
         end
         S_LP: begin
            add_a = prod_ff;
            add_b = si_ff;
         end
         S_FI: begin
            add_a = ghp_ff;
            add_b = bp_ff;
         end
         default: begin
            add_a = gbp_ff;
            add_b = lp_ff;
         end
      endcase
   end

   assign add_y = sat_add(add_a, add_b, add_sub);

   assign lp_conv = to_out(lp_ff);
   assign bp_conv = to_out(bp_ff);
   assign hp_conv = to_out(hp_ff);

   // configuration writes
   always_comb begin
      gain_in    = gain_ff;
      damping_in = damping_ff;
      norm_in    = norm_ff;
      select_in  = select_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CUTOFF_GAIN:   gain_in    = csr_write_data;
            CSR_DAMPING:       damping_in = csr_write_data;
            CSR_NORMALIZER:    norm_in    = csr_write_data;
            CSR_OUTPUT_SELECT: select_in  = csr_write_data[SEL_W-1:0];
            default: begin
               gain_in = gain_ff;
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   state_in = req_acc ? S_K_LO : S_IDLE;
         S_K_LO:   state_in = S_K_HI;
         S_K_HI:   state_in = S_K_FIN;
         S_K_FIN:  state_in = S_T_X;
         S_T_X:    state_in = S_T_S;
         S_T_S:    state_in = S_N_LO;
         S_N_LO:   state_in = S_N_HI;
         S_N_HI:   state_in = S_N_FIN;
         S_N_FIN:  state_in = S_G1_LO;
         S_G1_LO:  state_in = S_G1_HI;
         S_G1_HI:  state_in = S_G1_FIN;
         S_G1_FIN: state_in = S_BP;
         S_BP:     state_in = S_G2_LO;
         S_G2_LO:  state_in = S_G2_HI;
         S_G2_HI:  state_in = S_G2_FIN;
         S_G2_FIN: state_in = S_LP;
         S_LP:     state_in = S_FI;
         S_FI:     state_in = S_SI;
         S_SI:     state_in = advance ? S_IDLE : S_SI;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath registers
   always_comb begin
      x_in          = x_ff;
      t_in          = t_ff;
      hp_in         = hp_ff;
      ghp_in        = ghp_ff;
      bp_in         = bp_ff;
      gbp_in        = gbp_ff;
      lp_in         = lp_ff;
      fi_in         = fi_ff;
      si_in         = si_ff;
      prod_in       = prod_ff;
      plo_in        = plo_ff;
      phi_in        = phi_ff;
      mag_hi_in     = mag_hi_ff;
      coef_in       = coef_ff;
      neg_in        = neg_ff;
      norm_shift_in = norm_shift_ff;
      if (req_acc) begin
         x_in = to_state(req_chan.sample_in);
      end
      if (is_lo) begin
         plo_in        = mul_p;
         mag_hi_in     = op_abs[STATE_WIDTH-1:HALF_W];
         coef_in       = c_sel;
         neg_in        = op_a[STATE_WIDTH-1];
         norm_shift_in = (state_ff == S_N_LO);
      end
      if (is_hi) begin
         phi_in = PHI_W'(mul_p);
      end
      if (is_fin) begin
         prod_in = fin_val;
      end
      case (state_ff)
         S_T_X:   t_in = add_y;
         S_T_S:   t_in = add_y;
         S_G1_LO: hp_in = prod_ff;
         S_BP: begin
            bp_in  = add_y;
            ghp_in = prod_ff;
         end
         S_LP: begin
            lp_in  = add_y;
            gbp_in = prod_ff;
         end
         S_FI:    fi_in = add_y;
         S_SI: begin
            if (advance) begin
               si_in = add_y;
            end
         end
         default: begin
            t_in = t_ff;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      lp_out_in    = lp_out_ff;
      bp_out_in    = bp_out_ff;
      hp_out_in    = hp_out_ff;
      sel_out_in   = sel_out_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == S_SI) && advance) begin
         rsp_valid_in = 1'b1;
         lp_out_in    = lp_conv;
         bp_out_in    = bp_conv;
         hp_out_in    = hp_conv;
         case (select_ff)
            SEL_LOWPASS:  sel_out_in = lp_conv;
            SEL_BANDPASS: sel_out_in = bp_conv;
            default:      sel_out_in = hp_conv;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fi_ff        <= '0;
         si_ff        <= '0;
         gain_ff      <= CUTOFF_GAIN_RESET;
         damping_ff   <= DAMPING_RESET;
         norm_ff      <= NORMALIZER_RESET;
         select_ff    <= SELECT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fi_ff        <= fi_in;
         si_ff        <= si_in;
         gain_ff      <= gain_in;
         damping_ff   <= damping_in;
         norm_ff      <= norm_in;
         select_ff    <= select_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      t_ff          <= t_in;
      hp_ff         <= hp_in;
      ghp_ff        <= ghp_in;
      bp_ff         <= bp_in;
      gbp_ff        <= gbp_in;
      lp_ff         <= lp_in;
      prod_ff       <= prod_in;
      plo_ff        <= plo_in;
      phi_ff        <= phi_in;
      mag_hi_ff     <= mag_hi_in;
      coef_ff       <= coef_in;
      neg_ff        <= neg_in;
      norm_shift_ff <= norm_shift_in;
      lp_out_ff     <= lp_out_in;
      bp_out_ff     <= bp_out_in;
      hp_out_ff     <= hp_out_in;
      sel_out_ff    <= sel_out_in;
   end

`ifndef ASSERT_OFF
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == S_K_LO))
      else $error("accepted beat did not start the sequence");

   a_fi_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FI) |=> $stable(fi_ff))
      else $error("first integrator changed outside its update step");

   a_si_hold: assert property (@(posedge clock) disable iff (reset)
      !((state_ff == S_SI) && advance) |=> $stable(si_ff))
      else $error("second integrator changed outside its update step");

   a_sel_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((sel_out_ff == lp_out_ff) || (sel_out_ff == bp_out_ff) ||
                        (sel_out_ff == hp_out_ff)))
      else $error("selected output matches no response");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SI) && advance) |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("result beat not loaded at end of sequence");
`endif

endmodule

`default_nettype wire

@@ tb/svf_filter_checker.sv @@
`timescale 1ns / 1ps
// Monitors the filter channels, predicts every response beat and compares it field by field.
module svf_filter_checker (
   input  logic                   clock,
   input  logic                   reset,
   svf_req_if                     req_mon,
   svf_rsp_if                     rsp_mon,
   input  logic                   csr_write_enable,
   input  svf_pkg::csr_index_type csr_index,
   input  svf_pkg::csr_data_type  csr_write_data,
   output int                     fail_count,
   output int                     pending
);
   import svf_pkg::*;

   localparam int SAMPLE_W  = 16;
   localparam int STATE_W   = 32;
   localparam int FRAC_W    = STATE_W - 9;
   localparam int IN_SHIFT  = FRAC_W - (SAMPLE_W - 1);
   localparam int OUT_SHIFT = FRAC_W - (SAMPLE_W - 1);

   localparam longint STATE_MAX = (longint'(1) << (STATE_W - 1)) - 1;
   localparam longint STATE_MIN = -(longint'(1) << (STATE_W - 1));
   localparam longint OUT_MAX   = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint OUT_MIN   = -(longint'(1) << (SAMPLE_W - 1));

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] lowpass;
      logic signed [SAMPLE_W-1:0] bandpass;
      logic signed [SAMPLE_W-1:0] highpass;
      logic signed [SAMPLE_W-1:0] selected;
   } filter_out_type;

   csr_data_type    gain_q;
   csr_data_type    damp_q;
   csr_data_type    norm_q;
   sel_type         sel_q;
   longint          integ1;
   longint          integ2;
   filter_out_type  expected_q[$];
   filter_out_type  want;

   function automatic longint clamp_state(input longint v);
      if (v > STATE_MAX) return STATE_MAX;
      if (v < STATE_MIN) return STATE_MIN;
      return v;
   endfunction

   // value * coef / 2^frac, rounded half away from zero, saturated
   function automatic longint scale_coef(input longint v, input longint unsigned c,
                                         input int frac);
      longint unsigned mag;
      longint unsigned prod;
      bit              neg;
      neg  = v < 0;
      mag  = neg ? -v : v;
      prod = (mag * c + (64'd1 << (frac - 1))) >> frac;
      if (prod > (64'd1 << (STATE_W - 1))) prod = 64'd1 << (STATE_W - 1);
      return clamp_state(neg ? -longint'(prod) : longint'(prod));
   endfunction

   function automatic sample_type to_sample(input longint v);
      longint unsigned mag;
      longint          r;
      bit              neg;
      neg = v < 0;
      mag = neg ? -v : v;
      mag = (mag + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
      r   = neg ? -longint'(mag) : longint'(mag);
      if (r > OUT_MAX) r = OUT_MAX;
      if (r < OUT_MIN) r = OUT_MIN;
      return r[SAMPLE_W-1:0];
   endfunction

   function automatic filter_out_type filter_step(input sample_type s);
      longint          x, t, hp, bp, lp, ghp, gbp;
      longint unsigned k;
      filter_out_type  res;
      k   = (64'(damp_q) << DAMP_SHIFT) + 64'(gain_q);
      x   = clamp_state(longint'(s) <<< IN_SHIFT);
      t   = clamp_state(x - scale_coef(integ1, k, GAIN_FRAC));
      t   = clamp_state(t - integ2);
      hp  = scale_coef(t, 64'(norm_q), NORM_FRAC);
      ghp = scale_coef(hp, 64'(gain_q), GAIN_FRAC);
      bp  = clamp_state(ghp + integ1);
      gbp = scale_coef(bp, 64'(gain_q), GAIN_FRAC);
      lp  = clamp_state(gbp + integ2);
      integ1 = clamp_state(ghp + bp);
      integ2 = clamp_state(gbp + lp);
      res.lowpass  = to_sample(lp);
      res.bandpass = to_sample(bp);
      res.highpass = to_sample(hp);
      case (sel_q)
         SEL_LOWPASS:  res.selected = res.lowpass;
         SEL_BANDPASS: res.selected = res.bandpass;
         default:      res.selected = res.highpass;
      endcase
      return res;
   endfunction

   task automatic check_field(input string name, input sample_type exp_val,
                              input sample_type got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, got_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gain_q     = CUTOFF_GAIN_RESET;
         damp_q     = DAMPING_RESET;
         norm_q     = NORMALIZER_RESET;
         sel_q      = SELECT_RESET;
         integ1     = 0;
         integ2     = 0;
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(filter_step(req_mon.sample_in));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               $error("response beat with no sample outstanding: lowpass %0d",
                      rsp_mon.lowpass_out);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("lowpass_out", want.lowpass, rsp_mon.lowpass_out);
               check_field("bandpass_out", want.bandpass, rsp_mon.bandpass_out);
               check_field("highpass_out", want.highpass, rsp_mon.highpass_out);
               check_field("selected_out", want.selected, rsp_mon.selected_out);
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CUTOFF_GAIN:   gain_q = csr_write_data;
               CSR_DAMPING:       damp_q = csr_write_data;
               CSR_NORMALIZER:    norm_q = csr_write_data;
               CSR_OUTPUT_SELECT: sel_q  = csr_write_data[SEL_W-1:0];
               default: ;
            endcase
         end
      end
      pending = expected_q.size();
   end

endmodule

@@ tb/state_variable_filter_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top: drives samples and coefficient writes into the filter core and gives the verdict.
module state_variable_filter_core_tb;
   import svf_pkg::*;

   localparam int TOTAL_ITEMS   = 950;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 93;
   localparam int DRAIN_PAUSE   = 25;
   localparam int END_PAUSE     = 40;
   localparam int STALL_CYCLES  = 300;
   localparam int IDLE_LIMIT    = 4000;
   localparam int FIRST_UNUSED_INDEX = CSR_OUTPUT_SELECT + 1;
   localparam sel_type SEL_UNUSED = 2'd3;   // decodes as highpass

   logic          clock;
   logic          reset;
   logic          csr_write_enable;
   csr_index_type csr_index;
   csr_data_type  csr_write_data;
   int            fail_count;
   int            pending;
   int            samples_sent;
   int            settings_applied;
   int            send_idle = 32;
   int            recv_idle = 84;
   int            idle_cycles = 0;
   bit            stall_req = 1'b0;
   logic signed [15:0] walk_sample;

   svf_req_if #(.SAMPLE_WIDTH(16)) req_chan ();
   svf_rsp_if #(.SAMPLE_WIDTH(16)) rsp_chan ();

   state_variable_filter_core #(
      .SAMPLE_WIDTH(16),
      .STATE_WIDTH (32)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   svf_filter_checker u_filter_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: random backpressure plus one long hold on request
   initial begin
      int hold;
      bit stall_done;
      hold = 0;
      stall_done = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_req && !stall_done) begin
            hold = STALL_CYCLES;
            stall_done = 1'b1;
         end
         if (hold > 0) begin
            rsp_chan.ready = 1'b0;
            hold--;
         end else begin
            rsp_chan.ready = ($urandom_range(99) >= recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(9))
         0, 1, 2, 3: walk_sample = 16'($urandom);
         4, 5:       walk_sample = walk_sample + 16'($urandom_range(2047)) - 16'd1024;
         6:          walk_sample = 16'sh7FFF;
         7:          walk_sample = 16'sh8000;
         default:    walk_sample = 16'($urandom_range(255)) - 16'd128;
      endcase
      return walk_sample;
   endfunction

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_sample(input logic signed [15:0] s);
      if (samples_sent < TOTAL_ITEMS / 3) begin
         send_idle = 32;
         recv_idle = 84;
      end else if (samples_sent < 2 * TOTAL_ITEMS / 3) begin
         send_idle = 84;
         recv_idle = 32;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.sample_in = s;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      samples_sent++;
   endtask

   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_PAUSE) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input csr_data_type data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
   endtask

   task automatic program_setting(input csr_data_type gain, input csr_data_type damp,
                                  input csr_data_type norm, input sel_type sel);
      wait_drained();
      write_csr(CSR_CUTOFF_GAIN, gain);
      write_csr(CSR_DAMPING, damp);
      write_csr(CSR_NORMALIZER, norm);
      write_csr(CSR_OUTPUT_SELECT, csr_data_type'({$urandom, sel}));
      write_csr(csr_index_type'($urandom_range(FIRST_UNUSED_INDEX, 2**CSR_INDEX_W - 1)),
                csr_data_type'($urandom));
      csr_write_enable = 1'b0;
      settings_applied++;
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.sample_in = '0;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_CUTOFF_GAIN;
      csr_write_data     = '0;
      samples_sent       = 0;
      settings_applied   = 1;
      walk_sample        = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset coefficients, lowpass select: extremes and bit patterns
      send_sample(16'sd0);
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh8000);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      send_sample(16'sh5555);
      send_sample(16'shAAAA);
      send_sample(16'sd0);

      wait_drained();
      write_csr(CSR_OUTPUT_SELECT, csr_data_type'(SEL_BANDPASS));
      csr_write_enable = 1'b0;
      send_sample(16'sd12345);
      send_sample(-16'sd12345);

      wait_drained();
      write_csr(CSR_OUTPUT_SELECT, csr_data_type'(SEL_HIGHPASS));
      csr_write_enable = 1'b0;
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);

      // select code three with all upper data bits set
      wait_drained();
      write_csr(CSR_OUTPUT_SELECT, '1);
      csr_write_enable = 1'b0;
      send_sample(16'sd1000);
      send_sample(-16'sd1000);

      // writes to unused indexes must leave the coefficients alone
      wait_drained();
      for (int j = FIRST_UNUSED_INDEX; j < 2**CSR_INDEX_W; j++)
         write_csr(csr_index_type'(j), csr_data_type'($urandom));
      csr_write_enable = 1'b0;
      send_sample(16'sd500);

      // largest coefficients, normalizer above one: saturation everywhere
      wait_drained();
      write_csr(CSR_CUTOFF_GAIN, '1);
      write_csr(CSR_DAMPING, '1);
      write_csr(CSR_NORMALIZER, '1);
      csr_write_enable = 1'b0;
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);

      wait_drained();
      write_csr(CSR_NORMALIZER, '0);
      write_csr(CSR_CUTOFF_GAIN, '0);
      csr_write_enable = 1'b0;
      send_sample(16'sh7FFF);
      send_sample(16'sd0);
      settings_applied += 6;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: program_setting(24'd68719, 24'd92682, 24'd7648000, SEL_LOWPASS);
            1: program_setting('0, '0, '0, SEL_BANDPASS);
            2: program_setting('1, '1, '1, SEL_UNUSED);
            3: program_setting(24'd1, 24'd1, NORMALIZER_RESET, SEL_HIGHPASS);
            default: begin
               program_setting(
                  csr_data_type'(($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF)
                                                          : $urandom_range(24'h100000)),
                  csr_data_type'(($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF)
                                                          : $urandom_range(24'h40000)),
                  csr_data_type'(($urandom_range(4) == 0)
                                    ? $urandom_range(24'hFFFFFF, 24'h800000)
                                    : $urandom_range(24'h800000)),
                  sel_type'($urandom_range(3)));
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 4 && n == PHASE_ITEMS / 2) begin
               req_chan.valid = 1'b0;
               @(posedge clock);
               stall_req = 1'b1;
               @(negedge clock);
            end
            send_sample(pick_sample());
         end
      end

      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (END_PAUSE) @(posedge clock);
      $display("Ran %0d samples through %0d coefficient settings, all select codes,",
               samples_sent, settings_applied);
      $display("three idle mixes and a %0d-cycle response hold.", STALL_CYCLES);
      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
